// ===== hdl/pin3d_pkg.sv =====
// shared constants and types for the 3d improved gradient noise block
// no dependencies; used by pin3d_ram and perlin_improved_noise_3d
package pin3d_pkg;

	// default table depth, a power of two
	localparam int TABLE_SIZE_DEF = 256;
	// default number of fraction bits of the coordinates
	localparam int FRAC_BITS_DEF = 16;
	// width of one permutation byte
	localparam int TAB_W = 8;
	// fraction bits of the result
	localparam int OUT_FRAC = 16;
	localparam int OUT_W = 18;
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

endpackage

// ===== hdl/pin3d_ram.sv =====
// single-port table ram with registered read
// depends on pin3d_pkg for the default width and depth
module pin3d_ram #(
	parameter int WIDTH = pin3d_pkg::TAB_W,
	parameter int DEPTH = pin3d_pkg::TABLE_SIZE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hdl/perlin_improved_noise_3d.sv =====
// 3d improved gradient noise over a loaded byte permutation table
// depends on pin3d_pkg and pin3d_ram
//
// usage:
//   a request is taken at each rising edge with start high and busy low;
//   busy is always low, so a request may be issued in every cycle
//   op = load writes table_value at table_index and gives no result
//   op = eval gives one noise_value, signed q1.16, saturated
//   the result shows on noise_value for one cycle with result_strobe high;
//   results keep request order
//   throughput: one request per cycle, loads and evals mixed freely
//   the receiver cannot stall, so nothing is ever held back
//   the table is copied into 14 small rams (2 + 4 + 8 hash lookups); a load
//   writes each copy at the stage where that copy is read, so every eval sees
//   exactly the loads that were taken before it
//   an entry must be loaded before any eval reads it
//   reset clears the pipeline valid bits and the strobe; the table is
//   not cleared
//   TABLE_SIZE must be a power of two
module perlin_improved_noise_3d #(
	parameter int TABLE_SIZE = pin3d_pkg::TABLE_SIZE_DEF,
	parameter int FRAC_BITS = pin3d_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [0:0]                           op,
	input  logic [7:0]                           table_index,
	input  logic [7:0]                           table_value,
	input  logic signed [31:0]                   coord_x,
	input  logic signed [31:0]                   coord_y,
	input  logic signed [31:0]                   coord_z,
	output logic                                 result_strobe,
	output logic signed [pin3d_pkg::OUT_W-1:0]   noise_value
);

	localparam int F = FRAC_BITS;
	localparam int TB = $clog2(TABLE_SIZE);
	localparam int TW = pin3d_pkg::TAB_W;
	// width of 6t-15 and the quintic-fade coefficient
	localparam int KW = F + 5;
	// product width of every signed fixed-point multiply
	localparam int PW = 2 * F + 6;
	// gradient and lerp width
	localparam int GW = F + 3;
	localparam int DOWN = (F > pin3d_pkg::OUT_FRAC) ? F - pin3d_pkg::OUT_FRAC : 0;
	localparam int UP = (F < pin3d_pkg::OUT_FRAC) ? pin3d_pkg::OUT_FRAC - F : 0;
	localparam int RW = GW + 8;
	localparam int HALF_Q = 1 << (F - 1);
	localparam int HALF_DOWN = (DOWN > 0) ? (1 << (DOWN - 1)) : 0;

	localparam logic signed [KW-1:0] FIFTEEN_Q = KW'(15 << F);
	localparam logic signed [KW-1:0] TEN_Q = KW'(10 << F);
	localparam logic [F:0] ONE_Q = (F + 1)'(1 << F);
	localparam logic signed [GW-1:0] ONE_G = GW'(1 << F);
	localparam logic signed [RW-1:0] SAT_HI = RW'(pin3d_pkg::OUT_MAX);
	localparam logic signed [RW-1:0] SAT_LO = RW'(pin3d_pkg::OUT_MIN);

	// gradient pick: one of 12 directions toward cube edges, chosen by the low hash nibble
	function automatic logic signed [GW-1:0] grad(
		input logic [3:0] h,
		input logic signed [GW-1:0] dx,
		input logic signed [GW-1:0] dy,
		input logic signed [GW-1:0] dz
	);
		logic signed [GW-1:0] gu;
		logic signed [GW-1:0] gv;
		gu = (h < 4'd8) ? dx : dy;
		if (h < 4'd4) begin
			gv = dy;
		end else if (h == 4'd12 || h == 4'd14) begin
			gv = dx;
		end else begin
			gv = dz;
		end
		grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
	endfunction

	assign busy = 1'b0;

	// ---------------- control: valid bits ----------------
	logic vld_s1, vld_s2, vld_s3;
	pin3d_pkg::op_t op_s1, op_s2, op_s3;
	logic ev_s4, ev_s5, ev_s6, ev_s7, ev_s8;
	logic ld_s1, ld_s2, ld_s3;

	assign ld_s1 = vld_s1 && (op_s1 == pin3d_pkg::OP_LOAD);
	assign ld_s2 = vld_s2 && (op_s2 == pin3d_pkg::OP_LOAD);
	assign ld_s3 = vld_s3 && (op_s3 == pin3d_pkg::OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			ev_s4 <= 1'b0;
			ev_s5 <= 1'b0;
			ev_s6 <= 1'b0;
			ev_s7 <= 1'b0;
			ev_s8 <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			ev_s4 <= vld_s3 && (op_s3 == pin3d_pkg::OP_EVAL);
			ev_s5 <= ev_s4;
			ev_s6 <= ev_s5;
			ev_s7 <= ev_s6;
			ev_s8 <= ev_s7;
			result_strobe <= ev_s8;
		end
	end

	// ---------------- stage 1: split, first fade products, level-1 lookups ----------------
	logic [7:0] idx_s1, val_s1, idx_s2, val_s2, idx_s3, val_s3;
	logic signed [31:0] crd_s1 [3];
	logic [TB-1:0] cell_c1 [3];
	logic [F-1:0] fr_c1 [3];
	logic signed [PW-1:0] p1_c1 [3];
	logic [2*F-1:0] p2_c1 [3];

	always_comb begin
		logic signed [KW-1:0] kk;
		for (int a = 0; a < 3; a++) begin
			cell_c1[a] = crd_s1[a][F+TB-1:F];
			fr_c1[a] = crd_s1[a][F-1:0];
			kk = $signed(KW'({fr_c1[a], 2'b00})) + $signed(KW'({fr_c1[a], 1'b0})) - FIFTEEN_Q;
			p1_c1[a] = $signed({1'b0, fr_c1[a]}) * kk;
			p2_c1[a] = fr_c1[a] * fr_c1[a];
		end
	end

	logic [TW-1:0] rd1 [2];
	logic [TW-1:0] rd2 [4];
	logic [TW-1:0] rd3 [8];
	logic [TB-1:0] a1 [2];

	assign a1[0] = cell_c1[0];
	assign a1[1] = cell_c1[0] + TB'(1);

	for (genvar i = 0; i < 2; i++) begin : g_l1
		pin3d_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_ram (
			.clk   (clk),
			.en    (vld_s1),
			.we    (ld_s1),
			.addr  (ld_s1 ? idx_s1[TB-1:0] : a1[i]),
			.wdata (val_s1),
			.rdata (rd1[i])
		);
	end

	// ---------------- stage 2 ----------------
	logic [TB-1:0] cy_s2, cz_s2, cz_s3;
	logic [F-1:0] fr_s2 [3];
	logic [F-1:0] fr_s3 [3];
	logic [F-1:0] fr_s4 [3];
	logic signed [PW-1:0] p1_s2 [3];
	logic [2*F-1:0] p2_s2 [3];
	logic signed [KW-1:0] c_c2 [3];
	logic [2*F-1:0] p3_c2 [3];
	logic [TB-1:0] a2 [4];

	always_comb begin
		logic signed [PW-1:0] t1;
		logic [2*F-1:0] t2w;
		logic [F-1:0] t2;
		for (int a = 0; a < 3; a++) begin
			t1 = p1_s2[a] + PW'(HALF_Q);
			c_c2[a] = KW'(t1 >>> F) + TEN_Q;
			t2w = p2_s2[a] + (2 * F)'(HALF_Q);
			t2 = t2w[2*F-1:F];
			p3_c2[a] = t2 * fr_s2[a];
		end
	end

	assign a2[0] = rd1[0][TB-1:0] + cy_s2;
	assign a2[1] = a2[0] + TB'(1);
	assign a2[2] = rd1[1][TB-1:0] + cy_s2;
	assign a2[3] = a2[2] + TB'(1);

	for (genvar i = 0; i < 4; i++) begin : g_l2
		pin3d_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_ram (
			.clk   (clk),
			.en    (vld_s2),
			.we    (ld_s2),
			.addr  (ld_s2 ? idx_s2[TB-1:0] : a2[i]),
			.wdata (val_s2),
			.rdata (rd2[i])
		);
	end

	// ---------------- stage 3 ----------------
	logic signed [KW-1:0] c_s3 [3];
	logic [2*F-1:0] p3_s3 [3];
	logic signed [PW-1:0] p4_c3 [3];
	logic [TB-1:0] cb [4];
	logic [TB-1:0] a3 [8];

	always_comb begin
		logic [2*F-1:0] t3w;
		logic [F-1:0] t3;
		for (int a = 0; a < 3; a++) begin
			t3w = p3_s3[a] + (2 * F)'(HALF_Q);
			t3 = t3w[2*F-1:F];
			p4_c3[a] = $signed({1'b0, t3}) * c_s3[a];
		end
	end

	// corner bases in corner order: AA, BA, AB, BB
	assign cb[0] = rd2[0][TB-1:0] + cz_s3;
	assign cb[1] = rd2[2][TB-1:0] + cz_s3;
	assign cb[2] = rd2[1][TB-1:0] + cz_s3;
	assign cb[3] = rd2[3][TB-1:0] + cz_s3;

	for (genvar i = 0; i < 8; i++) begin : g_l3
		// corner bit 2 selects the z+1 row
		assign a3[i] = cb[i%4] + TB'(i / 4);
		pin3d_ram #(.WIDTH(TW), .DEPTH(TABLE_SIZE)) u_ram (
			.clk   (clk),
			.en    (vld_s3),
			.we    (ld_s3),
			.addr  (ld_s3 ? idx_s3[TB-1:0] : a3[i]),
			.wdata (val_s3),
			.rdata (rd3[i])
		);
	end

	// ---------------- stage 4: fade finish, gradients ----------------
	logic signed [PW-1:0] p4_s4 [3];
	logic [F:0] fd_c4 [3];
	logic signed [GW-1:0] g_c4 [8];

	always_comb begin
		logic signed [PW-1:0] t4;
		logic signed [GW-1:0] ox;
		logic signed [GW-1:0] oy;
		logic signed [GW-1:0] oz;
		for (int a = 0; a < 3; a++) begin
			t4 = (p4_s4[a] + PW'(HALF_Q)) >>> F;
			if (t4 < 0) begin
				fd_c4[a] = '0;
			end else if (t4 > $signed(PW'(ONE_Q))) begin
				fd_c4[a] = ONE_Q;
			end else begin
				fd_c4[a] = t4[F:0];
			end
		end
		for (int c = 0; c < 8; c++) begin
			ox = $signed(GW'(fr_s4[0])) - (c[0] ? ONE_G : '0);
			oy = $signed(GW'(fr_s4[1])) - (c[1] ? ONE_G : '0);
			oz = $signed(GW'(fr_s4[2])) - (c[2] ? ONE_G : '0);
			g_c4[c] = grad(rd3[c][3:0], ox, oy, oz);
		end
	end

	// ---------------- stage 5: x products ----------------
	logic signed [GW-1:0] g_s5 [8];
	logic [F:0] u_s5, v_s5, w_s5, v_s6, w_s6, w_s7;
	logic signed [PW-1:0] px_c5 [4];

	always_comb begin
		logic signed [GW:0] d;
		for (int k = 0; k < 4; k++) begin
			d = (GW + 1)'(g_s5[2*k+1]) - (GW + 1)'(g_s5[2*k]);
			px_c5[k] = $signed({1'b0, u_s5}) * d;
		end
	end

	// ---------------- stage 6: x lerps, y products ----------------
	logic signed [GW-1:0] gb_s6 [4];
	logic signed [PW-1:0] px_s6 [4];
	logic signed [GW-1:0] lx_c6 [4];
	logic signed [PW-1:0] py_c6 [2];

	always_comb begin
		logic signed [PW-1:0] t;
		logic signed [GW:0] d;
		for (int k = 0; k < 4; k++) begin
			t = (px_s6[k] + PW'(HALF_Q)) >>> F;
			lx_c6[k] = gb_s6[k] + GW'(t);
		end
		for (int j = 0; j < 2; j++) begin
			d = (GW + 1)'(lx_c6[2*j+1]) - (GW + 1)'(lx_c6[2*j]);
			py_c6[j] = $signed({1'b0, v_s6}) * d;
		end
	end

	// ---------------- stage 7: y lerps, z product ----------------
	logic signed [GW-1:0] lb_s7 [2];
	logic signed [PW-1:0] py_s7 [2];
	logic signed [GW-1:0] ly_c7 [2];
	logic signed [PW-1:0] pz_c7;

	always_comb begin
		logic signed [PW-1:0] t;
		logic signed [GW:0] d;
		for (int j = 0; j < 2; j++) begin
			t = (py_s7[j] + PW'(HALF_Q)) >>> F;
			ly_c7[j] = lb_s7[j] + GW'(t);
		end
		d = (GW + 1)'(ly_c7[1]) - (GW + 1)'(ly_c7[0]);
		pz_c7 = $signed({1'b0, w_s7}) * d;
	end

	// ---------------- stage 8: z lerp, scale to q1.16, saturate ----------------
	logic signed [GW-1:0] lb_s8;
	logic signed [PW-1:0] pz_s8;
	logic signed [pin3d_pkg::OUT_W-1:0] res_c8;

	always_comb begin
		logic signed [PW-1:0] t;
		logic signed [GW-1:0] r;
		logic signed [RW-1:0] rr;
		t = (pz_s8 + PW'(HALF_Q)) >>> F;
		r = lb_s8 + GW'(t);
		rr = RW'(r);
		if (DOWN > 0) begin
			rr = (rr + RW'(HALF_DOWN)) >>> DOWN;
		end else begin
			rr = rr <<< UP;
		end
		if (rr > SAT_HI) begin
			rr = SAT_HI;
		end else if (rr < SAT_LO) begin
			rr = SAT_LO;
		end
		res_c8 = rr[pin3d_pkg::OUT_W-1:0];
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		op_s1 <= pin3d_pkg::op_t'(op);
		idx_s1 <= table_index;
		val_s1 <= table_value;
		crd_s1[0] <= coord_x;
		crd_s1[1] <= coord_y;
		crd_s1[2] <= coord_z;

		op_s2 <= op_s1;
		idx_s2 <= idx_s1;
		val_s2 <= val_s1;
		cy_s2 <= cell_c1[1];
		cz_s2 <= cell_c1[2];
		fr_s2 <= fr_c1;
		p1_s2 <= p1_c1;
		p2_s2 <= p2_c1;

		op_s3 <= op_s2;
		idx_s3 <= idx_s2;
		val_s3 <= val_s2;
		cz_s3 <= cz_s2;
		fr_s3 <= fr_s2;
		c_s3 <= c_c2;
		p3_s3 <= p3_c2;

		fr_s4 <= fr_s3;
		p4_s4 <= p4_c3;

		g_s5 <= g_c4;
		u_s5 <= fd_c4[0];
		v_s5 <= fd_c4[1];
		w_s5 <= fd_c4[2];

		for (int k = 0; k < 4; k++) begin
			gb_s6[k] <= g_s5[2*k];
		end
		px_s6 <= px_c5;
		v_s6 <= v_s5;
		w_s6 <= w_s5;

		lb_s7[0] <= lx_c6[0];
		lb_s7[1] <= lx_c6[2];
		py_s7 <= py_c6;
		w_s7 <= w_s6;

		lb_s8 <= ly_c7[0];
		pz_s8 <= pz_c7;

		noise_value <= res_c8;
	end

	// ---------------- assertions ----------------
	a_eval_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && op_s1 == pin3d_pkg::OP_EVAL) |-> ##8 result_strobe)
		else $error("eval request did not produce a result after 8 cycles");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s1 |-> ##8 !result_strobe)
		else $error("load request produced a result");

	a_fade_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s5 |-> (u_s5 <= ONE_Q && v_s5 <= ONE_Q && w_s5 <= ONE_Q))
		else $error("fade weight above one");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for perlin_improved_noise_3d: fills the permutation table,
// runs directed and random noise requests and checks each noise_value against a predictor
// depends on pin3d_pkg and the perlin_improved_noise_3d rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint ONE_Q = 64'sd65536;
	localparam longint HALF_Q = 64'sd32768;

	// scoreboard: own copy of the table plus the queue of pending noise values
	class noise_scoreboard;
		logic [7:0] perm [256];
		logic signed [pin3d_pkg::OUT_W-1:0] pending_noise [$];
		int errors;

		function new();
			errors = 0;
			foreach (perm[i]) perm[i] = 8'd0;
		endfunction

		// product of two q16 values, rounded half up
		function longint qmul(longint a, longint b);
			longint p;
			p = a * b + HALF_Q;
			return p >>> 16;
		endfunction

		// quintic fade 6t^5 - 15t^4 + 10t^3 in q16
		function longint fade(longint t);
			longint c, t2, t3, f;
			c = qmul(t, 6 * t - 15 * ONE_Q) + 10 * ONE_Q;
			t2 = qmul(t, t);
			t3 = qmul(t2, t);
			f = qmul(t3, c);
			if (f < 0) f = 0;
			if (f > ONE_Q) f = ONE_Q;
			return f;
		endfunction

		function longint blend(longint t, longint a, longint b);
			return a + qmul(t, b - a);
		endfunction

		// 12-direction gradient picked by the low four hash bits
		function longint grad(logic [7:0] hv, longint dx, longint dy, longint dz);
			logic [3:0] h;
			longint u, v;
			h = hv[3:0];
			u = (h < 8) ? dx : dy;
			v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
			return (h[0] ? -u : u) + (h[1] ? -v : v);
		endfunction

		function longint predict_noise(logic signed [31:0] cx, logic signed [31:0] cy,
				logic signed [31:0] cz);
			logic [7:0] gx, gy, gz, a, b, aa, ab, ba, bb;
			longint x, y, z, x1, y1, z1, u, v, w, r;
			// floor split: cell is the low byte of the integer part, fraction is unsigned
			gx = cx[23:16];
			gy = cy[23:16];
			gz = cz[23:16];
			x = longint'({16'd0, cx[15:0]});
			y = longint'({16'd0, cy[15:0]});
			z = longint'({16'd0, cz[15:0]});
			x1 = x - ONE_Q;
			y1 = y - ONE_Q;
			z1 = z - ONE_Q;
			u = fade(x);
			v = fade(y);
			w = fade(z);
			// hash sums wrap at 8 bits
			a = perm[gx] + gy;
			b = perm[8'(gx + 8'd1)] + gy;
			aa = perm[a] + gz;
			ab = perm[8'(a + 8'd1)] + gz;
			ba = perm[b] + gz;
			bb = perm[8'(b + 8'd1)] + gz;
			r = blend(w,
				blend(v,
					blend(u, grad(perm[aa], x, y, z), grad(perm[ba], x1, y, z)),
					blend(u, grad(perm[ab], x, y1, z), grad(perm[bb], x1, y1, z))),
				blend(v,
					blend(u, grad(perm[8'(aa + 8'd1)], x, y, z1),
						grad(perm[8'(ba + 8'd1)], x1, y, z1)),
					blend(u, grad(perm[8'(ab + 8'd1)], x, y1, z1),
						grad(perm[8'(bb + 8'd1)], x1, y1, z1))));
			if (r > pin3d_pkg::OUT_MAX) r = pin3d_pkg::OUT_MAX;
			if (r < pin3d_pkg::OUT_MIN) r = pin3d_pkg::OUT_MIN;
			return r;
		endfunction

		// called for every accepted request
		function void note_request(pin3d_pkg::op_t op, logic [7:0] idx, logic [7:0] val,
				logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz);
			if (op == pin3d_pkg::OP_LOAD)
				perm[idx] = val;
			else
				pending_noise.push_back(pin3d_pkg::OUT_W'(predict_noise(cx, cy, cz)));
		endfunction

		function void check_result(logic signed [pin3d_pkg::OUT_W-1:0] actual);
			logic signed [pin3d_pkg::OUT_W-1:0] want;
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected noise_value %0d", $time, actual);
				errors++;
				return;
			end
			want = pending_noise.pop_front();
			if (actual !== want) begin
				$display("%0t: noise_value mismatch expected %0d actual %0d",
					$time, want, actual);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [0:0] op;
	logic [7:0] table_index;
	logic [7:0] table_value;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic result_strobe;
	logic signed [pin3d_pkg::OUT_W-1:0] noise_value;

	noise_scoreboard sb;
	int cycle_count;

	perlin_improved_noise_3d uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.table_index(table_index),
		.table_value(table_value),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.result_strobe(result_strobe),
		.noise_value(noise_value)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL perlin_improved_noise_3d");
			$finish;
		end
	end

	// results are accepted at the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1)
			sb.check_result(noise_value);
	end

	// random idle length: mostly none or short, now and then long
	function int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// drive one request at the falling edge, wait for acceptance, then idle
	task send_request(pin3d_pkg::op_t rq_op, logic [7:0] idx, logic [7:0] val,
			logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz,
			int gap);
		@(negedge clk);
		start = 1'b1;
		op = rq_op;
		table_index = idx;
		table_value = val;
		coord_x = cx;
		coord_y = cy;
		coord_z = cz;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(rq_op, idx, val, cx, cy, cz);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			// scramble the idle payload so it is clearly ignored
			op = 1'($urandom);
			coord_x = $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task send_load(logic [7:0] idx, logic [7:0] val, int gap);
		send_request(pin3d_pkg::OP_LOAD, idx, val, $urandom, $urandom, $urandom, gap);
	endtask

	task send_eval(logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cz, int gap);
		send_request(pin3d_pkg::OP_EVAL, 8'($urandom), 8'($urandom), cx, cy, cz, gap);
	endtask

	// random coordinate: full range, near the origin, or on a lattice edge
	function logic signed [31:0] pick_coord();
		int r;
		r = $urandom_range(9);
		if (r < 4) return $urandom;
		if (r < 8) return 32'($signed($urandom_range(2097152)) - 1048576);
		if (r == 8) return {16'($urandom_range(65535)), 16'h0000};
		return {16'($urandom_range(65535)), 16'hffff};
	endfunction

	logic [7:0] shuffle [256];
	logic [7:0] tmp;
	int j;

	initial begin
		sb = new();
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = pin3d_pkg::OP_LOAD;
		table_index = 8'd0;
		table_value = 8'd0;
		coord_x = 32'sd0;
		coord_y = 32'sd0;
		coord_z = 32'sd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole table with a random permutation so no read hits an unwritten entry
		foreach (shuffle[i]) shuffle[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			send_load(8'(i), shuffle[i], (i % 37 == 5) ? 2 : 0);

		// directed: extremes, lattice points, negative floor, fraction edges
		send_eval(32'sd0, 32'sd0, 32'sd0, 0);
		send_eval(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_eval(32'h80000000, 32'h80000000, 32'h80000000, 1);
		send_eval(-32'sd1, -32'sd1, -32'sd1, 0);
		send_eval(32'h0000ffff, 32'h0000ffff, 32'h0000ffff, 0);
		send_eval(32'h00008000, 32'h00008000, 32'h00008000, 0);
		send_eval(32'h00010000, -32'sd65536, 32'h00ff0000, 0);
		send_eval(-32'sd98304, 32'h00018000, -32'sd1, 3);
		send_eval(32'h80000000, 32'h7fffffff, 32'sd0, 0);
		send_eval(32'h12345678, -32'sd305419896, 32'h0000abcd, 0);
		// large bytes, extreme index, then overwrite the same entry with an eval between
		send_load(8'hff, 8'hff, 0);
		send_load(8'h00, 8'h00, 0);
		send_eval(32'h00ff8000, 32'h00ff4000, 32'h00ffc000, 0);
		send_load(8'h00, 8'hff, 0);
		send_eval(32'h00004000, 32'h00004000, 32'h00004000, 0);
		send_eval(32'h00ff8000, 32'h00ff4000, 32'h00ffc000, 5);

		// random mix; table stays fully written so loads may go anywhere
		for (int n = 0; n < 2000; n++) begin
			if ($urandom_range(99) < 15)
				send_load(8'($urandom), 8'($urandom), (n % 300 < 60) ? 0 : pick_gap());
			else
				send_eval(pick_coord(), pick_coord(), pick_coord(),
					(n % 300 < 60) ? 0 : pick_gap());
		end

		@(negedge clk);
		start = 1'b0;
		while (sb.pending_noise.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS perlin_improved_noise_3d");
		else
			$display("FAIL perlin_improved_noise_3d");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pin3d_pkg.sv
hdl/pin3d_ram.sv
hdl/perlin_improved_noise_3d.sv
verif/testbench.sv
